[src/ptp_pkg.sv]
// Shared types, constants and codes for the parallax table pointing block.
// No dependencies; imported by ptp_div and the top level.
package ptp_pkg;

  // Table geometry
  localparam int DEFAULT_TABLE_DEPTH = 64;

  // Action codes
  localparam logic [2:0] ACT_CLEAR = 3'd0;
  localparam logic [2:0] ACT_ADD   = 3'd1;
  localparam logic [2:0] ACT_MOVE  = 3'd2;
  localparam logic [2:0] ACT_FIND  = 3'd3;
  localparam logic [2:0] ACT_CHECK = 3'd4;

  // Status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_MISS = 2'd2;

  // Fixed-point constants
  localparam logic [23:0] ONE_M       = 24'd65536;
  localparam logic [23:0] MAX_M       = 24'd1966080;
  localparam logic [23:0] TWENTY_M    = 24'd1310720;
  localparam logic [24:0] TENTH_M     = 25'd6554;
  localparam logic [31:0] HALF_Q16    = 32'h0000_8000;
  localparam logic [31:0] NEG_ONE_Q16 = 32'hFFFF_0000;
  localparam logic [32:0] FALLBACK_NUM = 33'd536643279;
  localparam logic [32:0] TWO_POW_32  = 33'h1_0000_0000;
  localparam logic [46:0] LOOKUP_LIMIT = 47'd5000 << 32;
  localparam logic [32:0] DIFF_LIMIT  = 33'd8388608;

  // Divider step counts
  localparam logic [5:0] DIV_STEPS_FRAC = 6'd30;
  localparam logic [5:0] DIV_STEPS_INT  = 6'd33;

  // One table entry
  typedef struct packed {
    logic [23:0] rng;
    logic [31:0] az;
    logic [31:0] el;
  } entry_t;

  // Divider request and response
  typedef struct packed {
    logic        start;
    logic [5:0]  steps;
    logic [47:0] rem_init;
    logic [32:0] dividend;
    logic [47:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [32:0] quo;
  } div_rsp_t;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE, S_EXEC, S_RADGO, S_RADW, S_MSTART, S_SCAN0, S_SCAN, S_SEL,
    S_NUM, S_DEN, S_FRGO, S_FRW, S_BLAZ, S_BLEL, S_BLFIN, S_FBGO, S_FBW,
    S_GAZ, S_GEL, S_GFIN, S_LRD, S_LSQA, S_LSQE, S_LCMP, S_LEND, S_DONE
  } state_t;

endpackage

[src/ptp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; width and depth come from parameters.
module ptp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/ptp_div.sv]
// Restoring shift-subtract divider, one quotient bit per cycle.
// Depends on ptp_pkg for the request and response structs.
module ptp_div import ptp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic        busy;
  logic [5:0]  cnt;
  logic [47:0] rem;
  logic [32:0] dvd;
  logic [32:0] quo;
  logic [47:0] dsr;
  logic [48:0] sh;
  logic        fits;

  // Shift in the next dividend bit and trial-subtract
  assign sh   = {rem, dvd[32]};
  assign fits = sh >= {1'b0, dsr};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= req.steps;
    end else if (busy) begin
      if (cnt == 6'd0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 6'd1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem_init;
      dvd <= req.dividend;
      dsr <= req.divisor;
      quo <= '0;
    end else if (busy && cnt != 6'd0) begin
      rem <= fits ? 48'(sh - {1'b0, dsr}) : sh[47:0];
      dvd <= {dvd[31:0], 1'b0};
      quo <= {quo[31:0], fits};
    end
  end

  assign rsp.done = busy && (cnt == 6'd0);
  assign rsp.quo  = quo;

endmodule

[src/parallax_table_pointing.sv]
// Top level of the parallax table pointing block: sequencer, multiplier, table.
// Depends on ptp_pkg, ptp_ram and ptp_div.
//
// One word is taken at a time. A distance lookup reads the table and squares
// two differences per stored point on the shared multiplier. A movement scans
// the table; when the distance falls inside a segment it adds two multiplies,
// the 30-step fraction divide and the blend. On an empty table it skips the
// scan and runs the fallback divide. A laser hit adds the radius divide. The
// divider gives one quotient bit per cycle. A finished result waits in the
// output register while the next word is taken.
module parallax_table_pointing import ptp_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [23:0] range_m,
  input  logic [31:0] image_az,
  input  logic [31:0] image_el,
  input  logic [31:0] tracker_az,
  input  logic [31:0] tracker_el,
  input  logic        laser_hit,
  input  logic        rear_camera,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] target_az,
  output logic [31:0] target_el,
  output logic [31:0] seek_radius,
  output logic [23:0] found_range,
  output logic        flag,
  output logic [1:0]  status
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t state, state_next;

  // Latched input word
  logic [2:0]  act_q;
  logic [23:0] rng_q;
  logic [31:0] img_az_q, img_el_q, trk_az_q, trk_el_q;
  logic        hit_q, rear_q;

  // Persistent state
  logic [31:0]   gain;
  logic [CW-1:0] count;
  logic [23:0]   last_rng;

  // Working registers
  logic [23:0]   d;
  logic [AW-1:0] idx;
  entry_t        first_ent, prev_ent;
  entry_t        seg1, seg2;
  logic          seg_found;
  logic [47:0]   num;
  logic [29:0]   t30;
  logic [31:0]   las_az, las_el;
  logic [45:0]   sq_a;
  logic [46:0]   best;
  logic          hit_found;
  logic [65:0]   prod;

  // Result under construction
  logic [31:0] r_az, r_el, r_rad;
  logic [23:0] r_found;
  logic        r_flag;
  logic [1:0]  r_status;

  // Control
  logic          accept, load_out, full;
  logic [CW-1:0] idx_nxt;
  logic          more;
  logic [32:0]   mul_a, mul_b;
  div_req_t      div_req;
  div_rsp_t      div_rsp;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_raddr;
  logic [87:0]   ram_rdata;
  entry_t        rd_ent, wr_ent;

  // Combinational datapath helpers
  logic [23:0] d_clamp;
  logic [28:0] r20;
  logic [32:0] seg_daz, seg_del, g_daz, g_del, l_da, l_de;
  logic        l_ok;
  logic [46:0] l_dist;

  function automatic logic [32:0] sub33(input logic [31:0] a, input logic [31:0] b);
    return {a[31], a} - {b[31], b};
  endfunction

  function automatic logic [32:0] mag33(input logic [32:0] x);
    return x[32] ? (~x + 33'd1) : x;
  endfunction

  function automatic logic [31:0] blend(input logic [31:0] a1, input logic neg,
                                        input logic [32:0] part);
    logic [33:0] s;
    s = neg ? ({{2{a1[31]}}, a1} - {1'b0, part}) : ({{2{a1[31]}}, a1} + {1'b0, part});
    return s[31:0];
  endfunction

  function automatic logic [31:0] steer(input logic [31:0] trk, input logic neg,
                                        input logic [40:0] res);
    logic [42:0] s;
    s = neg ? ({{11{trk[31]}}, trk} - {2'b0, res}) : ({{11{trk[31]}}, trk} + {2'b0, res});
    if (!s[42] && (|s[41:31])) begin
      return 32'h7FFF_FFFF;
    end else if (s[42] && !(&s[41:31])) begin
      return 32'h8000_0000;
    end
    return s[31:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign load_out  = (state == S_DONE) && (!out_valid || out_ready);
  assign full      = count >= CW'(TABLE_DEPTH);
  assign idx_nxt   = CW'(idx) + CW'(1);
  assign more      = idx_nxt < count;

  assign d_clamp = (rng_q > MAX_M) ? MAX_M : ((rng_q < ONE_M) ? ONE_M : rng_q);
  assign r20     = {1'b0, rng_q, 4'b0} + {3'b0, rng_q, 2'b0};

  assign rd_ent  = entry_t'(ram_rdata);
  assign wr_ent  = '{rng: rng_q, az: img_az_q, el: img_el_q};
  assign seg_daz = sub33(seg2.az, seg1.az);
  assign seg_del = sub33(seg2.el, seg1.el);
  assign g_daz   = sub33(las_az, img_az_q);
  assign g_del   = sub33(las_el, img_el_q);
  assign l_da    = sub33(img_az_q, rd_ent.az);
  assign l_de    = sub33(img_el_q, rd_ent.el);
  assign l_ok    = ($signed(l_da) < $signed(DIFF_LIMIT)) && ($signed(l_da) > -$signed(DIFF_LIMIT))
                && ($signed(l_de) < $signed(DIFF_LIMIT)) && ($signed(l_de) > -$signed(DIFF_LIMIT));
  assign l_dist  = {1'b0, sq_a} + {1'b0, prod[45:0]};

  // Point table
  ptp_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_DEPTH)) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (count[AW-1:0]),
    .wr_data (wr_ent),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Shared divider
  ptp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_EXEC;
      S_EXEC: begin
        case (act_q)
          ACT_MOVE: state_next = (hit_q && rng_q != 24'd0) ? S_RADGO : S_MSTART;
          ACT_FIND: state_next = (count == '0) ? S_DONE : S_LRD;
          default:  state_next = S_DONE;
        endcase
      end
      S_RADGO:  state_next = S_RADW;
      S_RADW:   if (div_rsp.done) state_next = S_MSTART;
      S_MSTART: state_next = (count == '0) ? S_FBGO : S_SCAN0;
      S_SCAN0:  state_next = S_SCAN;
      S_SCAN:   if (!more) state_next = S_SEL;
      S_SEL: begin
        if (d >= prev_ent.rng || d < first_ent.rng || !seg_found) begin
          state_next = S_GAZ;
        end else begin
          state_next = S_NUM;
        end
      end
      S_NUM:    state_next = S_DEN;
      S_DEN:    state_next = S_FRGO;
      S_FRGO:   state_next = S_FRW;
      S_FRW:    if (div_rsp.done) state_next = S_BLAZ;
      S_BLAZ:   state_next = S_BLEL;
      S_BLEL:   state_next = S_BLFIN;
      S_BLFIN:  state_next = S_GAZ;
      S_FBGO:   state_next = S_FBW;
      S_FBW:    if (div_rsp.done) state_next = S_GAZ;
      S_GAZ:    state_next = S_GEL;
      S_GEL:    state_next = S_GFIN;
      S_GFIN:   state_next = S_DONE;
      S_LRD:    state_next = S_LSQA;
      S_LSQA:   state_next = S_LSQE;
      S_LSQE:   state_next = S_LCMP;
      S_LCMP:   state_next = more ? S_LRD : S_LEND;
      S_LEND:   state_next = S_DONE;
      S_DONE:   if (load_out) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Control outputs: handshake, table port, multiplier operands, divider
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = idx;
    mul_a     = '0;
    mul_b     = '0;
    div_req   = '0;
    unique case (state)
      S_IDLE:  in_ready = 1'b1;
      S_EXEC:  ram_we = (act_q == ACT_ADD) && !full;
      S_RADGO: begin
        div_req.start    = 1'b1;
        div_req.steps    = DIV_STEPS_INT;
        div_req.dividend = TWO_POW_32;
        div_req.divisor  = {19'b0, r20};
      end
      S_SCAN0: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      S_SCAN: begin
        ram_re    = more;
        ram_raddr = idx_nxt[AW-1:0];
      end
      S_NUM: begin
        mul_a = {9'b0, d - seg1.rng};
        mul_b = {9'b0, seg2.rng};
      end
      S_DEN: begin
        mul_a = {9'b0, d};
        mul_b = {9'b0, seg2.rng - seg1.rng};
      end
      S_FRGO: begin
        div_req.start    = 1'b1;
        div_req.steps    = DIV_STEPS_FRAC;
        div_req.rem_init = num;
        div_req.divisor  = prod[47:0];
      end
      S_BLAZ: begin
        mul_a = mag33(seg_daz);
        mul_b = {3'b0, t30};
      end
      S_BLEL: begin
        mul_a = mag33(seg_del);
        mul_b = {3'b0, t30};
      end
      S_FBGO: begin
        div_req.start    = 1'b1;
        div_req.steps    = DIV_STEPS_INT;
        div_req.dividend = FALLBACK_NUM;
        div_req.divisor  = {24'b0, d};
      end
      S_GAZ: begin
        mul_a = mag33(g_daz);
        mul_b = {1'b0, gain};
      end
      S_GEL: begin
        mul_a = mag33(g_del);
        mul_b = {1'b0, gain};
      end
      S_LRD:   ram_re = 1'b1;
      S_LSQA: begin
        mul_a = {10'b0, l_da[32] ? 23'(~l_da + 33'd1) : l_da[22:0]};
        mul_b = mul_a;
      end
      S_LSQE: begin
        mul_a = {10'b0, l_de[32] ? 23'(~l_de + 33'd1) : l_de[22:0]};
        mul_b = mul_a;
      end
      default: ;
    endcase
  end

  // State and persistent registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      gain     <= '0;
      count    <= '0;
      last_rng <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        gain <= cfg_data;
      end
      if (state == S_EXEC && act_q == ACT_CLEAR) begin
        count    <= '0;
        last_rng <= '0;
      end else if (ram_we) begin
        count    <= count + CW'(1);
        last_rng <= rng_q;
      end
    end
  end

  // Shared multiplier, registered product
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Working datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          act_q    <= action;
          rng_q    <= range_m;
          img_az_q <= image_az;
          img_el_q <= image_el;
          trk_az_q <= tracker_az;
          trk_el_q <= tracker_el;
          hit_q    <= laser_hit;
          rear_q   <= rear_camera;
        end
      end
      S_EXEC: begin
        r_az      <= '0;
        r_el      <= '0;
        r_rad     <= '0;
        r_found   <= '0;
        r_flag    <= 1'b0;
        r_status  <= STAT_OK;
        d         <= d_clamp;
        idx       <= '0;
        seg_found <= 1'b0;
        best      <= LOOKUP_LIMIT;
        hit_found <= 1'b0;
        case (act_q)
          ACT_ADD: begin
            if (full) begin
              r_status <= STAT_FULL;
            end else begin
              r_flag <= rng_q > TWENTY_M;
            end
          end
          ACT_CHECK: r_flag <= {1'b0, rng_q} >= ({1'b0, last_rng} + TENTH_M);
          ACT_MOVE:  if (hit_q && rng_q == 24'd0) r_rad <= 32'hFFFF_FFFF;
          ACT_FIND:  if (count == '0) r_status <= STAT_MISS;
          default: ;
        endcase
      end
      S_RADW:  if (div_rsp.done) r_rad <= div_rsp.quo[31:0];
      // Walk the table, keep the first, the previous and the last matching segment
      S_SCAN: begin
        if (idx == '0) begin
          first_ent <= rd_ent;
        end else if (d >= prev_ent.rng && d < rd_ent.rng) begin
          seg1      <= prev_ent;
          seg2      <= rd_ent;
          seg_found <= 1'b1;
        end
        prev_ent <= rd_ent;
        if (more) idx <= idx_nxt[AW-1:0];
      end
      // Pick the end points or mark a miss
      S_SEL: begin
        if (d >= prev_ent.rng) begin
          las_az <= prev_ent.az;
          las_el <= prev_ent.el;
        end else if (d < first_ent.rng) begin
          las_az <= first_ent.az;
          las_el <= first_ent.el;
        end else if (!seg_found) begin
          las_az   <= NEG_ONE_Q16;
          las_el   <= NEG_ONE_Q16;
          r_status <= STAT_MISS;
        end
      end
      S_DEN:   num <= prod[47:0];
      S_FRW:   if (div_rsp.done) t30 <= div_rsp.quo[29:0];
      S_BLEL:  las_az <= blend(seg1.az, seg_daz[32], prod[62:30]);
      S_BLFIN: las_el <= blend(seg1.el, seg_del[32], prod[62:30]);
      S_FBW: begin
        if (div_rsp.done) begin
          las_az <= HALF_Q16;
          las_el <= HALF_Q16 + div_rsp.quo[31:0];
        end
      end
      // Apply the gain correction with saturation
      S_GEL:   r_az <= steer(trk_az_q, g_daz[32] ^ rear_q, prod[64:24]);
      S_GFIN:  r_el <= steer(trk_el_q, g_del[32] ^ rear_q, prod[64:24]);
      S_LSQE:  sq_a <= prod[45:0];
      // Keep the first nearest point
      S_LCMP: begin
        if (l_ok && l_dist < best) begin
          best      <= l_dist;
          r_found   <= rd_ent.rng;
          hit_found <= 1'b1;
        end
        if (more) idx <= idx_nxt[AW-1:0];
      end
      S_LEND:  if (!hit_found) r_status <= STAT_MISS;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      target_az   <= r_az;
      target_el   <= r_el;
      seek_radius <= r_rad;
      found_range <= r_found;
      flag        <= r_flag;
      status      <= r_status;
    end
  end

endmodule
